// ----- hdl/rmm_pkg.sv -----
// ---------------------------------------------------------------------------
// rmm_pkg: shared types and constants
// Field widths, access codes and address map of the bus-side memory map.
// ---------------------------------------------------------------------------
`default_nettype none

package rmm_pkg;

    // field widths
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int OP_W    = 2;
    localparam int BANK_W  = 2;
    localparam int SHIFT_W = 4;

    localparam int STORE_DEPTH = 1 << ADDR_W;

    // access codes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

    // address map
    localparam logic [ADDR_W-1:0] RAM_LO     = 16'h0000;
    localparam logic [ADDR_W-1:0] RAM_HI     = 16'h7FFF;
    localparam logic [ADDR_W-1:0] MODE_LO    = 16'hDF80;
    localparam logic [ADDR_W-1:0] MODE_HI    = 16'hDF87;
    localparam logic [ADDR_W-1:0] SYNC_LO    = 16'hDF88;
    localparam logic [ADDR_W-1:0] SYNC_HI    = 16'hDF8F;
    localparam logic [ADDR_W-1:0] EXP_LO     = 16'hDF90;
    localparam logic [ADDR_W-1:0] EXP_HI     = 16'hDF9F;
    localparam logic [ADDR_W-1:0] SERIAL     = 16'hDF93;
    localparam logic [ADDR_W-1:0] SERIAL_CTL = 16'hDF94;
    localparam logic [ADDR_W-1:0] PAD_ONE    = 16'hDF9C;
    localparam logic [ADDR_W-1:0] PAD_TWO    = 16'hDF9D;
    localparam logic [ADDR_W-1:0] IRQ_LO     = 16'hDFA0;
    localparam logic [ADDR_W-1:0] IRQ_HI     = 16'hDFAF;
    localparam logic [ADDR_W-1:0] BEEP_LO    = 16'hDFB0;
    localparam logic [ADDR_W-1:0] BEEP_HI    = 16'hDFBF;
    localparam logic [ADDR_W-1:0] CART_LO    = 16'hDFC0;
    localparam logic [ADDR_W-1:0] CART_HI    = 16'hDFFF;

    // video mode reads back with the low nibble set
    localparam logic [DATA_W-1:0] MODE_READ_MASK = 8'h0F;

    // gamepad shift counter
    localparam logic [SHIFT_W-1:0] SHIFT_FULL = 4'd8;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX  = 4'd9;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
        logic cfg_write;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/rmm_ifs.sv -----
// ---------------------------------------------------------------------------
// rmm_ifs: channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface rmm_req_if;
    logic                         valid;
    logic                         ready;
    logic [rmm_pkg::OP_W-1:0]     operation;
    logic [rmm_pkg::ADDR_W-1:0]   address;
    logic [rmm_pkg::DATA_W-1:0]   write_data;
    logic [rmm_pkg::DATA_W-1:0]   pad_one_buttons;
    logic [rmm_pkg::DATA_W-1:0]   pad_two_buttons;
    logic [rmm_pkg::DATA_W-1:0]   sync_flags;

    modport source (output valid, operation, address, write_data,
                    pad_one_buttons, pad_two_buttons, sync_flags, input ready);
    modport sink   (input valid, operation, address, write_data,
                    pad_one_buttons, pad_two_buttons, sync_flags, output ready);
endinterface

interface rmm_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rmm_pkg::DATA_W-1:0]   read_data;
    logic                         screen_touched;
    logic [rmm_pkg::BANK_W-1:0]   screen_bank;
    logic                         beeper_level;
    logic                         interrupt_enable;
    logic                         access_fault;
    logic                         halt_request;

    modport source (output valid, read_data, screen_touched, screen_bank,
                    beeper_level, interrupt_enable, access_fault, halt_request,
                    input ready);
    modport sink   (input valid, read_data, screen_touched, screen_bank,
                    beeper_level, interrupt_enable, access_fault, halt_request,
                    output ready);
endinterface

interface rmm_cfg_if;
    logic valid;
    logic ready;
    logic stop_on_fault;

    modport source (output valid, stop_on_fault, input ready);
    modport sink   (input valid, stop_on_fault, output ready);
endinterface

`default_nettype wire

// ----- hdl/rmm_ram.sv -----
// ---------------------------------------------------------------------------
// rmm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rmm_ctrl.sv -----
// ---------------------------------------------------------------------------
// rmm_ctrl: access controller
// Sequences capture and commit of one bus transaction and owns the
// handshakes of the request, response and configuration channels.
// ---------------------------------------------------------------------------
`default_nettype none

module rmm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output      logic          in_ready,
    output      logic          out_valid,
    input  wire logic          out_ready,
    input  wire logic          cfg_valid,
    output      logic          cfg_ready,
    output      rmm_pkg::cmd_t cmd
);

    rmm_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            can_commit;

    assign in_ready   = (state_reg == rmm_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cfg_ready  = 1'b1;
    assign can_commit = !out_valid_reg || out_ready;

    // command decode
    always_comb
    begin
        cmd.capture   = in_valid && in_ready;
        cmd.commit    = (state_reg == rmm_pkg::ST_EXEC) && can_commit;
        cmd.cfg_write = cfg_valid;
    end

    // next state and output flag
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            rmm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rmm_pkg::ST_EXEC;
                end
            end
            rmm_pkg::ST_EXEC:
            begin
                if (can_commit)
                begin
                    state_next     = rmm_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = rmm_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // an accepted transaction goes to execute and blocks the request side
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == rmm_pkg::ST_EXEC) && !in_ready)
        else $error("accepted transaction did not enter execute");

    // commit never overwrites a result still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit while output register is held");

    // a result only appears after an execute cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rmm_pkg::ST_EXEC))
        else $error("result raised without execute");

endmodule

`default_nettype wire

// ----- hdl/rmm_dp.sv -----
// ---------------------------------------------------------------------------
// rmm_dp: memory map datapath
// Request registers, byte store, I/O page registers, address decode and
// the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module rmm_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rmm_pkg::cmd_t                cmd,
    input  wire logic [rmm_pkg::OP_W-1:0]     operation,
    input  wire logic [rmm_pkg::ADDR_W-1:0]   address,
    input  wire logic [rmm_pkg::DATA_W-1:0]   write_data,
    input  wire logic [rmm_pkg::DATA_W-1:0]   pad_one_buttons,
    input  wire logic [rmm_pkg::DATA_W-1:0]   pad_two_buttons,
    input  wire logic [rmm_pkg::DATA_W-1:0]   sync_flags,
    input  wire logic                         cfg_stop_on_fault,
    output      logic [rmm_pkg::DATA_W-1:0]   read_data,
    output      logic                         screen_touched,
    output      logic [rmm_pkg::BANK_W-1:0]   screen_bank,
    output      logic                         beeper_level,
    output      logic                         interrupt_enable,
    output      logic                         access_fault,
    output      logic                         halt_request
);

    // captured request
    logic [rmm_pkg::OP_W-1:0]   op_reg;
    logic [rmm_pkg::ADDR_W-1:0] addr_reg;
    logic [rmm_pkg::DATA_W-1:0] wdata_reg;
    logic [rmm_pkg::DATA_W-1:0] pad_one_reg;
    logic [rmm_pkg::DATA_W-1:0] pad_two_reg;
    logic [rmm_pkg::DATA_W-1:0] sync_reg;

    // architectural state
    logic [rmm_pkg::DATA_W-1:0]  video_mode_reg, video_mode_next;
    logic [rmm_pkg::DATA_W-1:0]  pad_one_latch_reg, pad_one_latch_next;
    logic [rmm_pkg::DATA_W-1:0]  pad_two_latch_reg, pad_two_latch_next;
    logic [rmm_pkg::SHIFT_W-1:0] shift_count_reg, shift_count_next;
    logic                        beeper_reg, beeper_next;
    logic                        irq_reg, irq_next;
    logic                        stop_reg;

    // store bytes at DF9C and DF9D, kept in flops beside the RAM
    logic [rmm_pkg::DATA_W-1:0] pad_out_one_reg, pad_out_one_next;
    logic [rmm_pkg::DATA_W-1:0] pad_out_two_reg, pad_out_two_next;

    // result register
    logic [rmm_pkg::DATA_W-1:0] rd_reg;
    logic                       touched_reg;
    logic [rmm_pkg::BANK_W-1:0] bank_reg;
    logic                       beep_out_reg;
    logic                       irq_out_reg;
    logic                       fault_reg;
    logic                       halt_reg;

    // decode results
    logic [rmm_pkg::DATA_W-1:0] ram_q;
    logic [rmm_pkg::DATA_W-1:0] rd_val;
    logic                       touched;
    logic                       fault;
    logic                       mem_we;
    logic [rmm_pkg::ADDR_W-1:0] mem_waddr;
    logic [rmm_pkg::SHIFT_W-1:0] shift_sat;

    // byte store, read at capture, written at commit
    rmm_ram #(
        .WIDTH (rmm_pkg::DATA_W),
        .DEPTH (rmm_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.commit && mem_we),
        .waddr (mem_waddr),
        .wdata (wdata_reg),
        .re    (cmd.capture),
        .raddr (address),
        .rdata (ram_q)
    );

    assign shift_sat = (shift_count_reg < rmm_pkg::SHIFT_MAX)
                     ? shift_count_reg + 4'd1 : shift_count_reg;

    // access decode
    always_comb
    begin
        rd_val             = '0;
        touched            = 1'b0;
        fault              = 1'b0;
        mem_we             = 1'b0;
        mem_waddr          = addr_reg;
        video_mode_next    = video_mode_reg;
        pad_one_latch_next = pad_one_latch_reg;
        pad_two_latch_next = pad_two_latch_reg;
        shift_count_next   = shift_count_reg;
        beeper_next        = beeper_reg;
        irq_next           = irq_reg;
        pad_out_one_next   = pad_out_one_reg;
        pad_out_two_next   = pad_out_two_reg;
        case (op_reg)
            rmm_pkg::OP_READ:
            begin
                case (addr_reg) inside
                    [rmm_pkg::MODE_LO:rmm_pkg::MODE_HI]:
                        rd_val = video_mode_reg | rmm_pkg::MODE_READ_MASK;
                    [rmm_pkg::SYNC_LO:rmm_pkg::SYNC_HI]:
                        rd_val = sync_reg;
                    rmm_pkg::SERIAL:
                        rd_val = '0;
                    rmm_pkg::PAD_ONE:
                        rd_val = pad_out_one_reg;
                    rmm_pkg::PAD_TWO:
                        rd_val = pad_out_two_reg;
                    [rmm_pkg::IRQ_LO:rmm_pkg::BEEP_HI]:
                        fault = 1'b1;
                    default:
                        rd_val = ram_q;
                endcase
            end
            rmm_pkg::OP_WRITE:
            begin
                case (addr_reg) inside
                    [rmm_pkg::RAM_LO:rmm_pkg::RAM_HI]:
                    begin
                        mem_we  = 1'b1;
                        touched = (addr_reg[14:13] == video_mode_reg[5:4]);
                    end
                    [rmm_pkg::MODE_LO:rmm_pkg::MODE_HI]:
                    begin
                        video_mode_next = wdata_reg;
                        touched         = 1'b1;
                    end
                    [rmm_pkg::SYNC_LO:rmm_pkg::SYNC_HI]:
                        fault = 1'b1;
                    rmm_pkg::SERIAL, rmm_pkg::SERIAL_CTL:
                    begin
                        // serial port not present
                    end
                    rmm_pkg::PAD_ONE:
                    begin
                        pad_one_latch_next = pad_one_reg;
                        pad_two_latch_next = pad_two_reg;
                        shift_count_next   = '0;
                    end
                    rmm_pkg::PAD_TWO:
                    begin
                        shift_count_next = shift_sat;
                        if (shift_sat == rmm_pkg::SHIFT_FULL)
                        begin
                            pad_out_one_next = ~pad_one_latch_reg;
                            pad_out_two_next = ~pad_two_latch_reg;
                        end
                        else
                        begin
                            pad_out_one_next = '0;
                            pad_out_two_next = '0;
                        end
                    end
                    [rmm_pkg::EXP_LO:rmm_pkg::EXP_HI]:
                        mem_we = 1'b1;
                    [rmm_pkg::IRQ_LO:rmm_pkg::IRQ_HI]:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = rmm_pkg::IRQ_LO;
                        irq_next  = wdata_reg[0];
                        touched   = 1'b1;
                    end
                    [rmm_pkg::BEEP_LO:rmm_pkg::BEEP_HI]:
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = rmm_pkg::BEEP_LO;
                        beeper_next = wdata_reg[0];
                    end
                    [rmm_pkg::CART_LO:rmm_pkg::CART_HI]:
                        mem_we = 1'b1;
                    default:
                        fault = 1'b1;
                endcase
            end
            rmm_pkg::OP_LOAD:
            begin
                // raw image fill, no decode but the pad bytes at DF9C and DF9D
                mem_we = 1'b1;
                if (addr_reg == rmm_pkg::PAD_ONE)
                begin
                    pad_out_one_next = wdata_reg;
                end
                if (addr_reg == rmm_pkg::PAD_TWO)
                begin
                    pad_out_two_next = wdata_reg;
                end
            end
            default:
            begin
                // unused code, no access
            end
        endcase
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= operation;
            addr_reg    <= address;
            wdata_reg   <= write_data;
            pad_one_reg <= pad_one_buttons;
            pad_two_reg <= pad_two_buttons;
            sync_reg    <= sync_flags;
        end
    end

    // I/O page state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_mode_reg    <= '0;
            pad_one_latch_reg <= '0;
            pad_two_latch_reg <= '0;
            shift_count_reg   <= '0;
            beeper_reg        <= 1'b0;
            irq_reg           <= 1'b0;
            stop_reg          <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                video_mode_reg    <= video_mode_next;
                pad_one_latch_reg <= pad_one_latch_next;
                pad_two_latch_reg <= pad_two_latch_next;
                shift_count_reg   <= shift_count_next;
                beeper_reg        <= beeper_next;
                irq_reg           <= irq_next;
            end
            if (cmd.cfg_write)
            begin
                stop_reg <= cfg_stop_on_fault;
            end
        end
    end

    // shifted pad bytes and result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            pad_out_one_reg <= pad_out_one_next;
            pad_out_two_reg <= pad_out_two_next;
            rd_reg          <= rd_val;
            touched_reg     <= touched;
            bank_reg        <= video_mode_next[5:4];
            beep_out_reg    <= beeper_next;
            irq_out_reg     <= irq_next;
            fault_reg       <= fault;
            halt_reg        <= fault && stop_reg;
        end
    end

    assign read_data        = rd_reg;
    assign screen_touched   = touched_reg;
    assign screen_bank      = bank_reg;
    assign beeper_level     = beep_out_reg;
    assign interrupt_enable = irq_out_reg;
    assign access_fault     = fault_reg;
    assign halt_request     = halt_reg;

endmodule

`default_nettype wire

// ----- hdl/retro_memory_map_io_decode.sv -----
// ---------------------------------------------------------------------------
// retro_memory_map_io_decode: bus-side memory map with I/O page decode
// 64K byte store, video mode, gamepad shifter, interrupt and beeper bits,
// access fault flags with optional halt request.
// ---------------------------------------------------------------------------
// flow: request and store read are registered at capture, then decoded and
//   committed to the result register; the next request is taken after that
//   commit; a held response does not block it, only delays its commit
// reset: rst_n async active low clears I/O registers, stop_on_fault and the
//   handshake state; store contents are undefined until written
// ---------------------------------------------------------------------------
`default_nettype none

module retro_memory_map_io_decode (
    input  wire logic clk,
    input  wire logic rst_n,
    rmm_req_if.sink   req,
    rmm_rsp_if.source rsp,
    rmm_cfg_if.sink   cfg
);

    rmm_pkg::cmd_t cmd;

    // controller
    rmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cmd       (cmd)
    );

    // datapath
    rmm_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .operation         (req.operation),
        .address           (req.address),
        .write_data        (req.write_data),
        .pad_one_buttons   (req.pad_one_buttons),
        .pad_two_buttons   (req.pad_two_buttons),
        .sync_flags        (req.sync_flags),
        .cfg_stop_on_fault (cfg.stop_on_fault),
        .read_data         (rsp.read_data),
        .screen_touched    (rsp.screen_touched),
        .screen_bank       (rsp.screen_bank),
        .beeper_level      (rsp.beeper_level),
        .interrupt_enable  (rsp.interrupt_enable),
        .access_fault      (rsp.access_fault),
        .halt_request      (rsp.halt_request)
    );

endmodule

`default_nettype wire
